@@ hdl/assert_macros.svh @@
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Sampled on clk, quiet while arst_n is low.
`define ASSERT_NOW(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Antecedent this cycle, consequent on the next.
`define ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) ante |=> cons) else $error(msg);

`endif

@@ hdl/jsu_pkg.sv @@
package jsu_pkg;

	localparam int SEQ_LEN     = 5;
	localparam int LEN_W       = $clog2(SEQ_LEN + 1);
	localparam int IDX_W       = $clog2(SEQ_LEN);
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_BSL   = 8'h5C;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_N     = 8'h6E;
	localparam logic [7:0] CH_R     = 8'h72;
	localparam logic [7:0] CH_T     = 8'h74;
	localparam logic [7:0] CH_B     = 8'h62;
	localparam logic [7:0] CH_F     = 8'h66;
	localparam logic [7:0] CH_U     = 8'h75;

	// One group of source characters, decoded token by token in the back end.
	// With uni set the group is a complete \uXXXX escape and cp holds the value of its leading hex digits.
	typedef struct packed {
		logic [SEQ_LEN-1:0][7:0] seq;
		logic [LEN_W-1:0]        len;
		logic                    uni;
		logic [15:0]             cp;
		logic                    last;
	} tok_t;

endpackage

@@ hdl/jsu_front.sv @@
module jsu_front (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           accept,
	input  logic [7:0]     in_byte,
	input  logic           in_last,
	output logic           push,
	output jsu_pkg::tok_t  tok
);
	import jsu_pkg::*;

	typedef enum logic [2:0] {
		PH_TEXT,
		PH_ESC,
		PH_U0,
		PH_U1,
		PH_U2,
		PH_U3
	} phase_t;

	phase_t     ph_q, ph_d;
	logic [7:0] held_q [3];
	logic       flush;

	function automatic logic [4:0] hex_val(input logic [7:0] c);
		if (c inside {[8'h30:8'h39]}) return {1'b0, 4'(c - 8'h30)};
		if (c inside {[8'h61:8'h66]}) return {1'b0, 4'(c - 8'h57)};
		if (c inside {[8'h41:8'h46]}) return {1'b0, 4'(c - 8'h37)};
		return 5'h10;
	endfunction

	// leading hex digits only; a non-hex character ends the number
	function automatic logic [15:0] cp_of(input logic [3:0][7:0] h);
		logic [15:0] v;
		logic        stop;
		logic [4:0]  d;
		v    = '0;
		stop = 1'b0;
		for (int k = 0; k < 4; k++) begin
			d = hex_val(h[k]);
			if (!stop && !d[4]) begin
				v = {v[11:0], d[3:0]};
			end else begin
				stop = 1'b1;
			end
		end
		return v;
	endfunction

	always_comb begin
		tok      = '0;
		tok.last = in_last;
		flush    = in_last;
		ph_d     = ph_q;
		case (ph_q)
			PH_TEXT: begin
				tok.seq[0] = in_byte;
				tok.len    = LEN_W'(1);
				if (in_byte != CH_BSL) begin
					flush = 1'b1;
				end else begin
					ph_d = PH_ESC;
				end
			end
			PH_ESC: begin
				tok.seq[0] = CH_BSL;
				tok.seq[1] = in_byte;
				tok.len    = LEN_W'(2);
				if (in_byte == CH_U) begin
					ph_d = PH_U0;
				end else begin
					flush = 1'b1;
					ph_d  = PH_TEXT;
				end
			end
			PH_U0: begin
				tok.seq[0] = CH_BSL;
				tok.seq[1] = CH_U;
				tok.seq[2] = in_byte;
				tok.len    = LEN_W'(3);
				ph_d       = PH_U1;
			end
			PH_U1: begin
				tok.seq[0] = CH_BSL;
				tok.seq[1] = CH_U;
				tok.seq[2] = held_q[0];
				tok.seq[3] = in_byte;
				tok.len    = LEN_W'(4);
				ph_d       = PH_U2;
			end
			PH_U2: begin
				tok.seq[0] = CH_BSL;
				tok.seq[1] = CH_U;
				tok.seq[2] = held_q[0];
				tok.seq[3] = held_q[1];
				tok.seq[4] = in_byte;
				tok.len    = LEN_W'(5);
				ph_d       = PH_U3;
			end
			PH_U3: begin
				tok.uni = 1'b1;
				tok.cp  = cp_of({in_byte, held_q[2], held_q[1], held_q[0]});
				flush   = 1'b1;
				ph_d    = PH_TEXT;
			end
			default: begin
				tok.seq[0] = in_byte;
				tok.len    = LEN_W'(1);
				ph_d       = PH_TEXT;
			end
		endcase
		if (in_last) begin
			ph_d = PH_TEXT;
		end
	end

	assign push = accept && flush;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q <= PH_TEXT;
		end else if (accept) begin
			ph_q <= ph_d;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && !in_last) begin
			if (ph_q == PH_U0) held_q[0] <= in_byte;
			if (ph_q == PH_U1) held_q[1] <= in_byte;
			if (ph_q == PH_U2) held_q[2] <= in_byte;
		end
	end

endmodule

@@ hdl/jsu_fifo.sv @@
module jsu_fifo (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  jsu_pkg::tok_t wr_tok,
	input  logic          pop,
	output jsu_pkg::tok_t rd_tok,
	output logic          nonempty,
	output logic          full
);
	import jsu_pkg::*;

	tok_t              mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_q, rd_q;
	logic [QCNT_W-1:0] cnt_q;
	logic              do_pop;

	assign nonempty = (cnt_q != '0);
	assign full     = (cnt_q == QCNT_W'(QUEUE_DEPTH));
	assign rd_tok   = mem_q[rd_q];
	assign do_pop   = pop && nonempty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + QPTR_W'(1);
			if (do_pop) rd_q <= rd_q + QPTR_W'(1);
			if (push && !do_pop) begin
				cnt_q <= cnt_q + QCNT_W'(1);
			end else if (!push && do_pop) begin
				cnt_q <= cnt_q - QCNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= wr_tok;
	end

endmodule

@@ hdl/jsu_back.sv @@
module jsu_back (
	input  logic          clk,
	input  logic          arst_n,
	input  logic [10:0]   cap,
	input  logic          q_valid,
	input  jsu_pkg::tok_t q_tok,
	output logic          pop,
	output logic          out_valid,
	input  logic          out_ready,
	output logic [7:0]    out_byte,
	output logic          byte_valid,
	output logic          out_last,
	output logic [9:0]    out_count
);
	import jsu_pkg::*;

	logic [10:0] prod_q;
	logic        full_q;

	logic                    buf_valid_q;
	logic [SEQ_LEN-1:0][7:0] buf_bytes_q;
	logic [LEN_W-1:0]        buf_n_q;
	logic [IDX_W-1:0]        buf_idx_q;
	logic                    buf_empty_q;
	logic                    buf_last_q;
	logic [9:0]              buf_base_q;

	logic                    out_valid_q, byte_valid_q, out_last_q;
	logic [7:0]              out_byte_q;
	logic [9:0]              out_count_q;

	logic [SEQ_LEN-1:0][7:0] bytes;
	logic [LEN_W-1:0]        nb;
	logic [11:0]             cnt, lim;
	logic                    full, skip, two;
	logic [7:0]              nxt;
	logic [8:0]              em;
	logic                    out_free, move, done, load;

	// [8] marks a known single-character escape
	function automatic logic [8:0] esc_map(input logic [7:0] c);
		case (c)
			CH_QUOTE, CH_BSL, CH_SLASH: return {1'b1, c};
			CH_N:    return 9'h10A;
			CH_R:    return 9'h10D;
			CH_T:    return 9'h109;
			CH_B:    return 9'h108;
			CH_F:    return 9'h10C;
			default: return 9'h000;
		endcase
	endfunction

	// token decode of the queue head against the room left
	always_comb begin
		bytes = '0;
		nb    = '0;
		lim   = {1'b0, cap};
		cnt   = {1'b0, prod_q};
		full  = full_q;
		skip  = 1'b0;
		two   = 1'b0;
		nxt   = '0;
		em    = '0;
		if (q_tok.uni) begin
			if (!full && (cnt + 12'd1 < lim)) begin
				if (q_tok.cp <= 16'h007F) begin
					bytes[0] = q_tok.cp[7:0];
					nb       = LEN_W'(1);
				end else if (q_tok.cp <= 16'h07FF) begin
					if (cnt + 12'd2 < lim) begin
						bytes[0] = 8'hC0 | {3'b000, q_tok.cp[10:6]};
						bytes[1] = 8'h80 | {2'b00, q_tok.cp[5:0]};
						nb       = LEN_W'(2);
					end
				end else if (cnt + 12'd3 < lim) begin
					bytes[0] = 8'hE0 | {4'b0000, q_tok.cp[15:12]};
					bytes[1] = 8'h80 | {2'b00, q_tok.cp[11:6]};
					bytes[2] = 8'h80 | {2'b00, q_tok.cp[5:0]};
					nb       = LEN_W'(3);
				end
				cnt = cnt + {9'd0, nb};
			end else begin
				full = 1'b1;
			end
		end else begin
			for (int i = 0; i < SEQ_LEN; i++) begin
				if ((LEN_W'(i) < q_tok.len) && !skip) begin
					nxt = q_tok.seq[(i + 1) % SEQ_LEN];
					em  = esc_map(nxt);
					two = (q_tok.seq[i] == CH_BSL) && (LEN_W'(i + 1) < q_tok.len) && em[8];
					if (!full && (cnt + 12'd1 < lim)) begin
						bytes[nb[IDX_W-1:0]] = two ? em[7:0] : q_tok.seq[i];
						nb  = nb + LEN_W'(1);
						cnt = cnt + 12'd1;
					end else begin
						full = 1'b1;
					end
					skip = two;
				end else begin
					skip = 1'b0;
				end
			end
		end
	end

	assign out_free = !out_valid_q || out_ready;
	assign move     = buf_valid_q && out_free;
	assign done     = (LEN_W'(buf_idx_q) + LEN_W'(1) == buf_n_q);
	assign pop      = q_valid && (!buf_valid_q || (move && done));
	assign load     = (nb != '0) || q_tok.last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prod_q      <= '0;
			full_q      <= 1'b0;
			buf_valid_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				prod_q      <= q_tok.last ? 11'd0 : cnt[10:0];
				full_q      <= q_tok.last ? 1'b0 : full;
				buf_valid_q <= load;
			end else if (move && done) begin
				buf_valid_q <= 1'b0;
			end
			if (move) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			buf_bytes_q <= bytes;
			buf_n_q     <= (nb == '0) ? LEN_W'(1) : nb;
			buf_empty_q <= (nb == '0);
			buf_last_q  <= q_tok.last;
			buf_base_q  <= prod_q[9:0];
			buf_idx_q   <= '0;
		end else if (move) begin
			buf_idx_q <= buf_idx_q + IDX_W'(1);
		end
		if (move) begin
			out_byte_q   <= buf_empty_q ? 8'h00 : buf_bytes_q[buf_idx_q];
			byte_valid_q <= !buf_empty_q;
			out_last_q   <= buf_last_q && done;
			out_count_q  <= buf_empty_q ? buf_base_q
			                            : buf_base_q + 10'(buf_idx_q) + 10'd1;
		end
	end

	assign out_valid  = out_valid_q;
	assign out_byte   = out_byte_q;
	assign byte_valid = byte_valid_q;
	assign out_last   = out_last_q;
	assign out_count  = out_count_q;

endmodule

@@ hdl/json_string_unescape.sv @@
// An item that yields output passes the queue entry, the back-end buffer and the output
// register. Throughput: one item per cycle while each yields at most one byte and out_ready
// is high; an item that yields more bytes holds the back-end buffer until all its bytes
// leave the one-byte output port, and a 4-entry queue lets input run on meanwhile.
// Reset (arst_n low): phase, counters, queue and output valid clear at once; capacity
// returns to min(1024, MAX_CAPACITY). Held escape characters are not cleared.
module json_string_unescape #(
	parameter int unsigned MAX_CAPACITY = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wen,
	input  logic [10:0] cfg_wdata,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  in_byte,
	input  logic        in_last,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  out_byte,
	output logic        byte_valid,
	output logic        out_last,
	output logic [9:0]  out_count
);
	import jsu_pkg::*;

	localparam logic [10:0] CAP_LIM = 11'(MAX_CAPACITY > 2047 ? 2047 : MAX_CAPACITY);
	localparam logic [10:0] CAP_RST = 11'(MAX_CAPACITY < 1024 ? MAX_CAPACITY : 1024);

	logic [10:0] cap_q;
	logic        accept, push, q_valid, q_full, pop;
	tok_t        push_tok, head_tok;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAP_RST;
		end else if (cfg_wen) begin
			cap_q <= (cfg_wdata > CAP_LIM) ? CAP_LIM : cfg_wdata;
		end
	end

	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;

	jsu_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.accept  (accept),
		.in_byte (in_byte),
		.in_last (in_last),
		.push    (push),
		.tok     (push_tok)
	);

	jsu_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.wr_tok   (push_tok),
		.pop      (pop),
		.rd_tok   (head_tok),
		.nonempty (q_valid),
		.full     (q_full)
	);

	jsu_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cap        (cap_q),
		.q_valid    (q_valid),
		.q_tok      (head_tok),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_byte   (out_byte),
		.byte_valid (byte_valid),
		.out_last   (out_last),
		.out_count  (out_count)
	);

endmodule

@@ hdl/jsu_checker.sv @@
`include "assert_macros.svh"

module jsu_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       in_last,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] out_byte,
	input logic       byte_valid,
	input logic       out_last,
	input logic [9:0] out_count
);

	logic [3:0] pend_q;
	logic       in_end, out_end;

	// strings taken in but not yet closed at the output
	assign in_end  = in_valid && in_ready && in_last;
	assign out_end = out_valid && out_ready && out_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else if (in_end && !out_end) begin
			pend_q <= pend_q + 4'd1;
		end else if (!in_end && out_end) begin
			pend_q <= pend_q - 4'd1;
		end
	end

	`ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_byte) && $stable(out_count) && $stable(out_last), "stalled item changed")
	`ASSERT_NOW(a_empty_last, out_valid && !byte_valid |-> out_last && out_byte == 8'h00, "empty item not final or not zero")
	`ASSERT_NOW(a_end_pending, out_end |-> pend_q != 4'd0, "string closed that was never taken in")

endmodule

bind json_string_unescape jsu_checker u_jsu_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_valid),
	.in_ready   (in_ready),
	.in_last    (in_last),
	.out_valid  (out_valid),
	.out_ready  (out_ready),
	.out_byte   (out_byte),
	.byte_valid (byte_valid),
	.out_last   (out_last),
	.out_count  (out_count)
);
